/* hdl/nsp_pkg.sv */
package nsp_pkg;

    localparam int NSP_QDEPTH = 4;
    localparam int NSP_QPTR_W = $clog2(NSP_QDEPTH);
    localparam int NSP_QCNT_W = $clog2(NSP_QDEPTH + 1);

    localparam logic [7:0] NSP_BYTE_ZERO = 8'h00;
    localparam logic [7:0] NSP_BYTE_ONE  = 8'h01;
    localparam logic [4:0] NSP_TYPE_MASK = 5'h1f;
    localparam logic [4:0] NSP_TYPE_IDR  = 5'd5;

    // Zero run saturates at three pending zeros.
    localparam logic [1:0] NSP_ZRUN_MAX = 2'd3;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               packet_end;
        logic signed [63:0] pts;
        logic signed [63:0] dts;
    } t_in;

    typedef struct packed {
        logic [7:0]         nal_byte;
        logic               first_of_nal;
        logic               last_of_nal;
        logic [4:0]         nal_type;
        logic               is_keyframe;
        logic signed [63:0] out_pts;
        logic signed [63:0] out_dts;
    } t_out;

    // One word of work for the back end: push nzero zero bytes, then the
    // data byte if push_b, then close the current NAL if close.
    typedef struct packed {
        logic [2:0]         nzero;
        logic               push_b;
        logic [7:0]         data_byte;
        logic               close;
        logic signed [63:0] pts;
        logic signed [63:0] dts;
    } t_op;

endpackage

/* hdl/nsp_front.sv */
module nsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nsp_pkg::t_in   i_data,
    output logic           o_push,
    output nsp_pkg::t_op   o_op,
    input  logic           i_full
);
    import nsp_pkg::*;

    logic [1:0] r_zero_run;
    logic [1:0] n_zero_run;
    logic [2:0] nzero;
    logic       push_b;
    logic       close;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_zero_run = r_zero_run;
        nzero      = 3'd0;
        push_b     = 1'b0;
        close      = 1'b0;
        if (i_data.data_byte == NSP_BYTE_ZERO) begin
            if (r_zero_run < NSP_ZRUN_MAX) begin
                n_zero_run = r_zero_run + 2'd1;
            end else begin
                // push the oldest pending zero out as payload
                nzero = 3'd1;
            end
        end else if (i_data.data_byte == NSP_BYTE_ONE && r_zero_run >= 2'd2) begin
            close      = 1'b1;
            n_zero_run = 2'd0;
        end else begin
            nzero      = {1'b0, r_zero_run};
            push_b     = 1'b1;
            n_zero_run = 2'd0;
        end
        if (i_data.packet_end) begin
            // flush pending zeros, then close
            nzero      = nzero + {1'b0, n_zero_run};
            n_zero_run = 2'd0;
            close      = 1'b1;
        end
    end

    assign o_push         = accept && (nzero != 3'd0 || push_b || close);
    assign o_op.nzero     = nzero;
    assign o_op.push_b    = push_b;
    assign o_op.data_byte = i_data.data_byte;
    assign o_op.close     = close;
    assign o_op.pts       = i_data.pts;
    assign o_op.dts       = i_data.dts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
        end else if (accept) begin
            r_zero_run <= n_zero_run;
        end
    end

endmodule

/* hdl/nsp_queue.sv */
module nsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nsp_pkg::t_op   i_op,
    output logic           o_full,
    input  logic           i_pop,
    output nsp_pkg::t_op   o_op,
    output logic           o_empty
);
    import nsp_pkg::*;

    t_op                   r_mem [NSP_QDEPTH];
    logic [NSP_QPTR_W-1:0] r_wptr;
    logic [NSP_QPTR_W-1:0] r_rptr;
    logic [NSP_QCNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == NSP_QCNT_W'(NSP_QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + NSP_QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + NSP_QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NSP_QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NSP_QCNT_W'(1);
            end
        end
    end

endmodule

/* hdl/nsp_back.sv */
module nsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nsp_pkg::t_op   i_op,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output nsp_pkg::t_out  o_data
);
    import nsp_pkg::*;

    localparam logic [1:0] K_ZERO  = 2'd0;
    localparam logic [1:0] K_BYTE  = 2'd1;
    localparam logic [1:0] K_CLOSE = 2'd2;

    logic [7:0] r_held_byte;
    logic       r_held_valid;
    logic       r_nal_open;
    logic [4:0] r_cur_type;
    logic [2:0] r_zcnt;
    logic       r_bdone;
    logic       r_ovalid;
    t_out       r_out;

    logic [1:0] kind;
    logic [7:0] push_val;
    logic       last_step;
    logic       out_free;
    logic       go;
    t_out       res;

    always_comb begin
        if (r_zcnt < i_op.nzero) begin
            kind = K_ZERO;
        end else if (i_op.push_b && !r_bdone) begin
            kind = K_BYTE;
        end else begin
            kind = K_CLOSE;
        end
    end

    always_comb begin
        case (kind)
            K_ZERO:  last_step = (r_zcnt + 3'd1 == i_op.nzero) && !i_op.push_b
                                 && !i_op.close;
            K_BYTE:  last_step = !i_op.close;
            K_CLOSE: last_step = 1'b1;
            default: last_step = 1'b1;
        endcase
    end

    assign push_val = (kind == K_BYTE) ? i_op.data_byte : NSP_BYTE_ZERO;
    assign out_free = !r_ovalid || i_ready;
    // hold the step while a held byte would have to go out and the output is full
    assign go       = !i_empty && (!r_held_valid || out_free);
    assign o_pop    = go && last_step;

    assign res.nal_byte     = r_held_byte;
    assign res.first_of_nal = !r_nal_open;
    assign res.last_of_nal  = (kind == K_CLOSE);
    assign res.nal_type     = r_cur_type & NSP_TYPE_MASK;
    assign res.is_keyframe  = (r_cur_type == NSP_TYPE_IDR);
    assign res.out_pts      = i_op.pts;
    assign res.out_dts      = i_op.dts;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (go && r_held_valid) begin
            r_out <= res;
        end
        if (go && kind != K_CLOSE) begin
            r_held_byte <= push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_nal_open   <= 1'b0;
            r_cur_type   <= 5'd0;
            r_zcnt       <= 3'd0;
            r_bdone      <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (go && r_held_valid) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (go) begin
                if (kind == K_CLOSE) begin
                    r_held_valid <= 1'b0;
                    r_nal_open   <= 1'b0;
                end else begin
                    if (r_held_valid) begin
                        r_nal_open <= 1'b1;
                    end else if (!r_nal_open) begin
                        r_cur_type <= push_val[4:0] & NSP_TYPE_MASK;
                    end
                    r_held_valid <= 1'b1;
                end
                if (last_step) begin
                    r_zcnt  <= 3'd0;
                    r_bdone <= 1'b0;
                end else if (kind == K_ZERO) begin
                    r_zcnt <= r_zcnt + 3'd1;
                end else if (kind == K_BYTE) begin
                    r_bdone <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/h264_annexb_nal_splitter_top.sv */
// A payload byte passes through the queue, the held-byte and the output registers.
// Throughput: one input byte per cycle while the queue is not full; the back end runs
// one push or close per cycle while the output is not stalled, so a byte that flushes
// k pending zeros takes k+1 steps there, plus a close step at packet end. A four-word
// queue between front and back absorbs those bursts. Reset: synchronous, active low;
// clears the zero run, queue, held byte, NAL state and output valid.
module h264_annexb_nal_splitter_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nsp_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output nsp_pkg::t_out  o_data
);
    import nsp_pkg::*;

    logic push;
    t_op  op_in;
    logic full;
    logic pop;
    t_op  op_out;
    logic empty;

    nsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .o_op    (op_in),
        .i_full  (full)
    );

    nsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_op    (op_out),
        .o_empty (empty)
    );

    nsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
